// File: hdl/sdl_pkg.sv
// Package for the sorted delay-list engine: default sizes, command, status,
// controller opcodes and the structs passed between modules. No dependencies.
package sdl_pkg;

   localparam int SDL_ITEM_SLOTS = 64;
   localparam int SDL_LIST_COUNT = 4;
   localparam int SDL_VALUE_BITS = 32;

   // Command codes of an input beat.
   localparam logic [1:0] CMD_INS_CURSOR = 2'd0;
   localparam logic [1:0] CMD_INS_SORTED = 2'd1;
   localparam logic [1:0] CMD_REMOVE     = 2'd2;

   // Status codes of a result beat.
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_LISTED   = 2'd1;
   localparam logic [1:0] ST_UNLISTED = 2'd2;

   // Datapath operations issued by the controller.
   localparam logic [3:0] OP_NONE       = 4'd0;
   localparam logic [3:0] OP_ACCEPT     = 4'd1;
   localparam logic [3:0] OP_INS_CURSOR = 4'd2;
   localparam logic [3:0] OP_INS_MAX    = 4'd3;
   localparam logic [3:0] OP_INS_SORT   = 4'd4;
   localparam logic [3:0] OP_RM_READ    = 4'd5;
   localparam logic [3:0] OP_TAKE_P     = 4'd6;
   localparam logic [3:0] OP_TAKE_Q     = 4'd7;
   localparam logic [3:0] OP_FIRST      = 4'd8;
   localparam logic [3:0] OP_STEP       = 4'd9;
   localparam logic [3:0] OP_STOP       = 4'd10;
   localparam logic [3:0] OP_LINK1      = 4'd11;
   localparam logic [3:0] OP_LINK2      = 4'd12;
   localparam logic [3:0] OP_UNLINK     = 4'd13;

   // How the remaining count of a response is formed.
   localparam logic [1:0] RK_COUNT = 2'd0;
   localparam logic [1:0] RK_ZERO  = 2'd1;
   localparam logic [1:0] RK_INC   = 2'd2;
   localparam logic [1:0] RK_DEC   = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [1:0]  list_select;
      logic [5:0]  item_handle;
      logic [31:0] item_value;
   } sdl_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [6:0] remaining_count;
   } sdl_rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic       respond;
      logic [1:0] rsp_status;
      logic [1:0] rsp_kind;
   } sdl_ctl_type;

   typedef struct packed {
      logic [1:0] command;
      logic       handle_ok;
      logic       owned;
      logic       value_max;
      logic       walk_go;
   } sdl_stat_type;

endpackage

// File: hdl/sdl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sdl_ctrl.sv
// Controller state machine of the sorted delay-list engine.
// Depends on sdl_pkg for opcodes, codes and the command and status structs.
module sdl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sdl_pkg::sdl_stat_type stat,
   output sdl_pkg::sdl_ctl_type  ctl
);
   import sdl_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_OWN   = 4'd1;
   localparam logic [3:0] S_FIRST = 4'd2;
   localparam logic [3:0] S_WALK  = 4'd3;
   localparam logic [3:0] S_PREV  = 4'd4;
   localparam logic [3:0] S_NEXT  = 4'd5;
   localparam logic [3:0] S_LINK1 = 4'd6;
   localparam logic [3:0] S_LINK2 = 4'd7;
   localparam logic [3:0] S_RM    = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in       = state_ff;
      ctl.op         = OP_NONE;
      ctl.respond    = 1'b0;
      ctl.rsp_status = ST_DONE;
      ctl.rsp_kind   = RK_COUNT;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.op   = OP_ACCEPT;
               state_in = S_OWN;
            end
         end
         S_OWN: begin
            if (stat.command inside {CMD_INS_CURSOR, CMD_INS_SORTED}) begin
               if (!stat.handle_ok || stat.owned) begin
                  ctl.respond    = 1'b1;
                  ctl.rsp_status = stat.handle_ok ? ST_LISTED : ST_UNLISTED;
                  state_in       = S_IDLE;
               end else if (stat.command == CMD_INS_CURSOR) begin
                  ctl.op   = OP_INS_CURSOR;
                  state_in = S_PREV;
               end else if (stat.value_max) begin
                  ctl.op   = OP_INS_MAX;
                  state_in = S_PREV;
               end else begin
                  ctl.op   = OP_INS_SORT;
                  state_in = S_FIRST;
               end
            end else if (stat.command == CMD_REMOVE) begin
               if (!stat.handle_ok || !stat.owned) begin
                  ctl.respond    = 1'b1;
                  ctl.rsp_status = ST_UNLISTED;
                  ctl.rsp_kind   = RK_ZERO;
                  state_in       = S_IDLE;
               end else begin
                  ctl.op   = OP_RM_READ;
                  state_in = S_RM;
               end
            end else begin
               ctl.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_PREV: begin
            ctl.op   = OP_TAKE_P;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            ctl.op   = OP_TAKE_Q;
            state_in = S_LINK1;
         end
         S_FIRST: begin
            ctl.op   = OP_FIRST;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (stat.walk_go) begin
               ctl.op = OP_STEP;
            end else begin
               ctl.op   = OP_STOP;
               state_in = S_LINK1;
            end
         end
         S_LINK1: begin
            ctl.op   = OP_LINK1;
            state_in = S_LINK2;
         end
         S_LINK2: begin
            ctl.op       = OP_LINK2;
            ctl.respond  = 1'b1;
            ctl.rsp_kind = RK_INC;
            state_in     = S_IDLE;
         end
         S_RM: begin
            ctl.op       = OP_UNLINK;
            ctl.respond  = 1'b1;
            ctl.rsp_kind = RK_DEC;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not leave idle");
   a_respond_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.respond |=> !busy)
      else $error("controller not idle after response");
   a_walk_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> ($past(state_ff) == S_FIRST || $past(state_ff) == S_WALK))
      else $error("walk entered from wrong state");
`endif

endmodule

// File: hdl/sdl_dpath.sv
// Datapath of the sorted delay-list engine: link, value and owner memories,
// list cursors and counts, walk registers and the response register.
// Depends on sdl_pkg and sdl_ram.
module sdl_dpath #(
   parameter int ITEM_SLOTS = 64,
   parameter int LIST_COUNT = 4,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sdl_pkg::sdl_req_type  req_item,
   input  sdl_pkg::sdl_ctl_type  ctl,
   output sdl_pkg::sdl_stat_type stat,
   output logic                  rsp_strobe,
   output sdl_pkg::sdl_rsp_type  rsp_item
);
   import sdl_pkg::*;

   localparam int IW    = $clog2(ITEM_SLOTS);
   localparam int NODES = ITEM_SLOTS + LIST_COUNT;
   localparam int NW    = $clog2(NODES);
   localparam int LW    = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
   localparam int CW    = $clog2(ITEM_SLOTS + 1);

   sdl_req_type           req_ff;
   logic [LW-1:0]         list_ff, list_in;
   logic [VALUE_BITS-1:0] val_ff;
   logic [NW-1:0]         p_ff, x_ff, q_ff;
   logic [NW-1:0]         cursor_ff [LIST_COUNT];
   logic [CW-1:0]         count_ff [LIST_COUNT];
   logic [ITEM_SLOTS-1:0] listed_ff;
   logic [NODES-1:0]      nxt_vld_ff, prv_vld_ff;
   logic [NW-1:0]         nxt_ra_ff, prv_ra_ff;
   logic                  rsp_strobe_ff;
   sdl_rsp_type           rsp_ff, rsp_in;

   logic [IW-1:0]         n_item;
   logic [NW-1:0]         n_node, sent, prev_node, next_node;
   logic [1:0]            sel_r;
   logic [CW-1:0]         cur_count, rem;

   logic                  nxt_we, nxt_re, prv_we, prv_re, val_we, val_re, own_we, own_re;
   logic [NW-1:0]         nxt_wa, nxt_wd, nxt_ra, prv_wa, prv_wd, prv_ra;
   logic [NW-1:0]         nxt_rd, prv_rd;
   logic [IW-1:0]         val_ra, own_ra;
   logic [VALUE_BITS-1:0] val_rd;
   logic [LW-1:0]         own_rd;

   assign n_item    = IW'(req_ff.item_handle);
   assign n_node    = NW'(n_item);
   assign sent      = NW'(ITEM_SLOTS) + NW'(list_ff);
   assign prev_node = prv_vld_ff[prv_ra_ff] ? prv_rd : prv_ra_ff;
   assign next_node = nxt_vld_ff[nxt_ra_ff] ? nxt_rd : nxt_ra_ff;
   assign cur_count = count_ff[list_ff];

   // Reduce the list number modulo the number of lists.
   always_comb begin
      sel_r = req_item.list_select;
      for (int k = 0; k < 3; k++) begin
         if (32'(sel_r) >= LIST_COUNT) begin
            sel_r = sel_r - 2'(LIST_COUNT);
         end
      end
      list_in = LW'(sel_r);
   end

   assign stat.command   = req_ff.command;
   assign stat.handle_ok = (32'(req_ff.item_handle) < ITEM_SLOTS);
   assign stat.owned     = listed_ff[n_item];
   assign stat.value_max = &val_ff;
   assign stat.walk_go   = (32'(x_ff) < ITEM_SLOTS) && (val_rd <= val_ff);

   always_comb begin
      nxt_we = 1'b0; nxt_wa = n_node; nxt_wd = q_ff; nxt_re = 1'b0; nxt_ra = sent;
      prv_we = 1'b0; prv_wa = q_ff;   prv_wd = n_node; prv_re = 1'b0; prv_ra = sent;
      val_we = 1'b0; val_re = 1'b0;   val_ra = IW'(next_node);
      own_we = 1'b0; own_re = 1'b0;   own_ra = IW'(req_item.item_handle);
      case (ctl.op)
         OP_ACCEPT: own_re = 1'b1;
         OP_INS_CURSOR: begin
            val_we = 1'b1;
            prv_re = 1'b1;
            prv_ra = cursor_ff[list_ff];
         end
         OP_INS_MAX: begin
            val_we = 1'b1;
            prv_re = 1'b1;
         end
         OP_INS_SORT: begin
            val_we = 1'b1;
            nxt_re = 1'b1;
         end
         OP_RM_READ: begin
            prv_re = 1'b1;
            prv_ra = n_node;
            nxt_re = 1'b1;
            nxt_ra = n_node;
         end
         OP_TAKE_P: begin
            nxt_re = 1'b1;
            nxt_ra = prev_node;
         end
         OP_FIRST, OP_STEP: begin
            nxt_re = 1'b1;
            nxt_ra = next_node;
            val_re = 1'b1;
         end
         OP_LINK1: begin
            nxt_we = 1'b1;
            prv_we = 1'b1;
         end
         OP_LINK2: begin
            nxt_we = 1'b1;
            nxt_wa = p_ff;
            nxt_wd = n_node;
            prv_we = 1'b1;
            prv_wa = n_node;
            prv_wd = p_ff;
            own_we = 1'b1;
         end
         OP_UNLINK: begin
            prv_we = 1'b1;
            prv_wa = next_node;
            prv_wd = prev_node;
            nxt_we = 1'b1;
            nxt_wa = prev_node;
            nxt_wd = next_node;
         end
         default: ;
      endcase
   end

   sdl_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_en(nxt_re), .rd_addr(nxt_ra), .rd_data(nxt_rd));

   sdl_ram #(.WIDTH(NW), .DEPTH(NODES)) u_prev (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_en(prv_re), .rd_addr(prv_ra), .rd_data(prv_rd));

   sdl_ram #(.WIDTH(VALUE_BITS), .DEPTH(ITEM_SLOTS)) u_value (
      .clock(clock), .wr_en(val_we), .wr_addr(n_item), .wr_data(val_ff),
      .rd_en(val_re), .rd_addr(val_ra), .rd_data(val_rd));

   sdl_ram #(.WIDTH(LW), .DEPTH(ITEM_SLOTS)) u_owner (
      .clock(clock), .wr_en(own_we), .wr_addr(n_item), .wr_data(list_ff),
      .rd_en(own_re), .rd_addr(own_ra), .rd_data(own_rd));

   always_comb begin
      case (ctl.rsp_kind)
         RK_ZERO: rem = '0;
         RK_INC:  rem = cur_count + CW'(1);
         RK_DEC:  rem = (cur_count != '0) ? cur_count - CW'(1) : cur_count;
         default: rem = cur_count;
      endcase
      rsp_in.status          = ctl.rsp_status;
      rsp_in.remaining_count = 7'(rem);
   end

   // Payload and walk registers.
   always_ff @(posedge clock) begin
      if (ctl.op == OP_ACCEPT) begin
         req_ff  <= req_item;
         list_ff <= list_in;
         val_ff  <= VALUE_BITS'(req_item.item_value);
      end
      if (ctl.op == OP_RM_READ) begin
         list_ff <= own_rd;
      end
      if (ctl.op == OP_INS_SORT) begin
         p_ff <= sent;
      end
      if (ctl.op == OP_TAKE_P) begin
         p_ff <= prev_node;
      end
      if (ctl.op == OP_FIRST) begin
         x_ff <= next_node;
      end
      if (ctl.op == OP_STEP) begin
         p_ff <= x_ff;
         x_ff <= next_node;
      end
      if (ctl.op == OP_TAKE_Q) begin
         q_ff <= next_node;
      end
      if (ctl.op == OP_STOP) begin
         q_ff <= x_ff;
      end
      if (nxt_re) begin
         nxt_ra_ff <= nxt_ra;
      end
      if (prv_re) begin
         prv_ra_ff <= prv_ra;
      end
      if (ctl.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   // Control state: valid bits, listed flags, cursors, counts, strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         nxt_vld_ff    <= '0;
         prv_vld_ff    <= '0;
         listed_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int l = 0; l < LIST_COUNT; l++) begin
            cursor_ff[l] <= NW'(ITEM_SLOTS + l);
            count_ff[l]  <= '0;
         end
      end else begin
         rsp_strobe_ff <= ctl.respond;
         if (nxt_we) begin
            nxt_vld_ff[nxt_wa] <= 1'b1;
         end
         if (prv_we) begin
            prv_vld_ff[prv_wa] <= 1'b1;
         end
         if (ctl.op == OP_LINK2) begin
            listed_ff[n_item] <= 1'b1;
         end
         if (ctl.op == OP_UNLINK) begin
            listed_ff[n_item] <= 1'b0;
         end
         for (int l = 0; l < LIST_COUNT; l++) begin
            if (32'(list_ff) == l) begin
               if (ctl.op == OP_LINK2) begin
                  count_ff[l] <= count_ff[l] + CW'(1);
               end
               if (ctl.op == OP_UNLINK) begin
                  if (count_ff[l] != '0) begin
                     count_ff[l] <= count_ff[l] - CW'(1);
                  end
                  if (cursor_ff[l] == n_node) begin
                     cursor_ff[l] <= prev_node;
                  end
               end
            end
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// File: hdl/sorted_delay_list_engine.sv
// Top level of the sorted delay-list engine: controller plus datapath.
// Depends on sdl_pkg, sdl_ctrl, sdl_dpath (and sdl_ram below it).
//
//   Channel   Ports                      Handshake
//   --------  -------------------------  ------------------------------------
//   request   start, busy, req_item      beat taken when start and not busy
//   response  rsp_strobe, rsp_item       beat valid for one cycle, no stall
//
// Every request beat produces exactly one response beat. The response
// appears in the cycle in which the controller is back in idle, so a new
// request can be taken in that same cycle.
// A rejected command answers straight after the ownership check, a remove reads
// its links and then unlinks, an insert before the cursor or at the tail reads
// its neighbours and then links, and a sorted insert first walks past listed
// items, one link per cycle, bounded by the next-link memory read port.
// Reset is synchronous and empties every list at once through valid bits on
// the link memories; no clearing pass is needed.
// The receiver cannot stall the response channel.
module sorted_delay_list_engine #(
   parameter int ITEM_SLOTS = sdl_pkg::SDL_ITEM_SLOTS,
   parameter int LIST_COUNT = sdl_pkg::SDL_LIST_COUNT,
   parameter int VALUE_BITS = sdl_pkg::SDL_VALUE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sdl_pkg::sdl_req_type req_item,
   output logic                 rsp_strobe,
   output sdl_pkg::sdl_rsp_type rsp_item
);
   import sdl_pkg::*;

   // Command and status between the controller and the datapath.
   sdl_ctl_type  ctl;
   sdl_stat_type stat;

   sdl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctl   (ctl)
   );

   sdl_dpath #(
      .ITEM_SLOTS (ITEM_SLOTS),
      .LIST_COUNT (LIST_COUNT),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .ctl        (ctl),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for sorted_delay_list_engine: holds a list model that
// predicts every response beat, and plain tasks that drive it. Depends on sdl_pkg.
`timescale 1ns / 100ps

// The scoreboard mirrors the list pool and queues one predicted response per
// accepted command beat.
class list_scoreboard;
   logic [31:0] node_val [64];
   logic [6:0]  nxt [68];
   logic [6:0]  prv [68];
   logic [2:0]  owner [64];
   logic [6:0]  cursor [4];
   logic [6:0]  count [4];
   sdl_pkg::sdl_rsp_type pending_rsp [$];
   int mismatches;

   function new();
      for (int i = 0; i < 64; i++) begin
         owner[i] = '0;
         node_val[i] = '0;
         nxt[i] = 7'(i);
         prv[i] = 7'(i);
      end
      for (int l = 0; l < 4; l++) begin
         nxt[64 + l] = 7'(64 + l);
         prv[64 + l] = 7'(64 + l);
         cursor[l] = 7'(64 + l);
         count[l] = '0;
      end
      mismatches = 0;
   endfunction

   function logic [31:0] key_of(logic [6:0] node);
      return (node < 64) ? node_val[node] : 32'hFFFF_FFFF;
   endfunction

   function void link_after(logic [6:0] p, logic [6:0] n);
      logic [6:0] q;
      q = nxt[p];
      nxt[n] = q;
      prv[q] = n;
      prv[n] = p;
      nxt[p] = n;
   endfunction

   function void note_command(sdl_pkg::sdl_req_type r);
      sdl_pkg::sdl_rsp_type e;
      logic [6:0] n, p, a, b;
      int own, guard;
      e.status = sdl_pkg::ST_DONE;
      e.remaining_count = count[r.list_select];
      n = {1'b0, r.item_handle};
      if (r.command == sdl_pkg::CMD_INS_CURSOR || r.command == sdl_pkg::CMD_INS_SORTED) begin
         if (owner[n] != 0) begin
            e.status = sdl_pkg::ST_LISTED;
         end else begin
            node_val[n] = r.item_value;
            if (r.command == sdl_pkg::CMD_INS_CURSOR) begin
               p = prv[cursor[r.list_select]];
            end else if (r.item_value == 32'hFFFF_FFFF) begin
               p = prv[64 + r.list_select];
            end else begin
               p = 7'(64 + r.list_select);
               guard = 0;
               while (key_of(nxt[p]) <= r.item_value && guard <= 64) begin
                  p = nxt[p];
                  guard++;
               end
            end
            link_after(p, n);
            owner[n] = 3'(r.list_select) + 3'd1;
            count[r.list_select]++;
            e.remaining_count = count[r.list_select];
         end
      end else if (r.command == sdl_pkg::CMD_REMOVE) begin
         e.remaining_count = 0;
         if (owner[n] == 0) begin
            e.status = sdl_pkg::ST_UNLISTED;
         end else begin
            own = int'(owner[n]) - 1;
            a = prv[n];
            b = nxt[n];
            prv[b] = a;
            nxt[a] = b;
            if (cursor[own] == n) cursor[own] = a;
            owner[n] = '0;
            if (count[own] > 0) count[own]--;
            e.remaining_count = count[own];
         end
      end
      pending_rsp.push_back(e);
   endfunction

   function void check_response(sdl_pkg::sdl_rsp_type got);
      sdl_pkg::sdl_rsp_type e;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: response beat with none expected: status %0d count %0d",
                     got.status, got.remaining_count);
         return;
      end
      e = pending_rsp.pop_front();
      if (got.status !== e.status || got.remaining_count !== e.remaining_count) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: expected status %0d count %0d, got status %0d count %0d",
                     e.status, e.remaining_count, got.status, got.remaining_count);
      end
   endfunction
endclass

module tb_top;
   import sdl_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   sdl_req_type req_item;
   logic        rsp_strobe;
   sdl_rsp_type rsp_item;

   list_scoreboard lists;
   int idle_cycles;
   bit quiet_stretch;

   sorted_delay_list_engine uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Both monitors wake at the rising edge before the design's registers have
   // updated, so they see the values that the edge itself samples. A response
   // always belongs to an earlier command beat, so the two may run in any order.
   always @(posedge clock) begin
      if (!reset && start && !busy) lists.note_command(req_item);
      if (!reset && rsp_strobe) lists.check_response(rsp_item);
   end

   // The watchdog counts cycles without any beat in either direction. A sorted
   // insert over a full list and the sender gaps both end well inside its limit,
   // so reaching the limit means the design has hung.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 4000) begin
            $display("FAIL sorted_delay_list_engine");
            $finish;
         end
      end
   end

   // Present one command beat and hold it until the design takes it. start is
   // left high, so a following beat goes out back to back.
   task automatic send_beat(sdl_req_type r);
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Sender gaps fall at random on about 14 beats in a hundred, except during
   // the quiet stretch in the middle of the random part.
   task automatic issue(sdl_req_type r);
      send_beat(r);
      if (!quiet_stretch && $urandom_range(99) < 14) pause_sender($urandom_range(1, 8));
   endtask

   // The monitor notes the last accepted beat at the same edge at which the
   // sender returns, so the wait looks at the queue from the next edge on.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (lists.pending_rsp.size() != 0);
   endtask

   function automatic sdl_req_type make_req(logic [1:0] c, logic [1:0] l, logic [5:0] h,
                                            logic [31:0] v);
      sdl_req_type r;
      r.command = c;
      r.list_select = l;
      r.item_handle = h;
      r.item_value = v;
      return r;
   endfunction

   // Random keys come half the time from a narrow range so that equal keys collide
   // often, with full-width keys and the wait-forever maximum mixed in.
   function automatic logic [31:0] random_key();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5) return $urandom_range(15);
      if (pick < 7) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic sdl_req_type random_req();
      logic [5:0] h;
      int pick;
      pick = $urandom_range(99);
      h = 6'($urandom_range(63));
      if (pick < 80) begin
         // Well-formed traffic: insert a free slot, or remove a listed one.
         if (lists.owner[h] == 0 && (pick < 50 || lists.pending_rsp.size() > 60))
            return make_req(2'($urandom_range(1)), 2'($urandom_range(3)), h, random_key());
         for (int k = 0; k < 64 && lists.owner[h] == 0; k++) h++;
         return make_req(CMD_REMOVE, 2'($urandom_range(3)), h, $urandom);
      end
      // Noise: unused command code, double inserts, stray removes.
      return make_req(2'($urandom_range(3)), 2'($urandom_range(3)), h, $urandom);
   endfunction

   initial begin
      lists = new();
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      quiet_stretch = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty-list cases, cursor and sorted inserts with equal
      // keys and both key extremes, double insert, stray remove, unused code.
      issue(make_req(CMD_REMOVE, 2'd0, 6'd0, 32'h0));
      issue(make_req(CMD_INS_SORTED, 2'd0, 6'd0, 32'h0));
      issue(make_req(CMD_INS_SORTED, 2'd0, 6'd63, 32'hFFFF_FFFF));
      issue(make_req(CMD_INS_SORTED, 2'd0, 6'd1, 32'h5));
      issue(make_req(CMD_INS_SORTED, 2'd0, 6'd2, 32'h5));
      issue(make_req(CMD_INS_SORTED, 2'd0, 6'd3, 32'h0));
      issue(make_req(CMD_INS_SORTED, 2'd0, 6'd4, 32'hFFFF_FFFE));
      issue(make_req(CMD_INS_SORTED, 2'd0, 6'd5, 32'hFFFF_FFFF));
      issue(make_req(CMD_INS_CURSOR, 2'd1, 6'd6, 32'hFFFF_FFFF));
      issue(make_req(CMD_INS_CURSOR, 2'd1, 6'd7, 32'h0));
      issue(make_req(CMD_INS_CURSOR, 2'd2, 6'd8, 32'hA5A5_5A5A));
      issue(make_req(CMD_INS_SORTED, 2'd3, 6'd9, 32'h5A5A_A5A5));
      issue(make_req(CMD_INS_CURSOR, 2'd3, 6'd0, 32'h1));
      issue(make_req(CMD_INS_SORTED, 2'd2, 6'd63, 32'h1));
      issue(make_req(2'd3, 2'd0, 6'd10, 32'hFFFF_FFFF));
      issue(make_req(2'd3, 2'd3, 6'd63, 32'h0));
      issue(make_req(CMD_REMOVE, 2'd3, 6'd1, 32'h0));
      issue(make_req(CMD_REMOVE, 2'd0, 6'd63, 32'h0));
      issue(make_req(CMD_REMOVE, 2'd1, 6'd7, 32'h0));
      issue(make_req(CMD_REMOVE, 2'd1, 6'd6, 32'h0));
      issue(make_req(CMD_REMOVE, 2'd1, 6'd6, 32'h0));
      issue(make_req(CMD_INS_SORTED, 2'd1, 6'd6, 32'h3));

      // Random part, with a gap-free stretch and one full drain midway.
      for (int i = 0; i < 500; i++) begin
         quiet_stretch = (i >= 150 && i < 250);
         if (i == 300) begin
            drain();
            repeat (5) @(posedge clock);
         end
         issue(random_req());
      end

      drain();
      repeat (20) @(posedge clock);
      if (lists.mismatches == 0 && lists.pending_rsp.size() == 0) begin
         $display("PASS sorted_delay_list_engine");
      end else begin
         $display("FAIL sorted_delay_list_engine");
      end
      $finish;
   end
endmodule
